FILE: src/bpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and constants of the directional Blinn-Phong shader.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned FracBitsDef = 14;
  localparam int unsigned ShineMax    = 255;
  localparam int unsigned VecW        = 16;
  localparam int unsigned ColW        = 16;
  localparam int unsigned RgbW        = 3 * ColW;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned HhW         = 34;
  localparam int unsigned LenW        = 17;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [VecW:0]   lvec_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIGHT_X   = 3'd0,
    CFG_LIGHT_Y   = 3'd1,
    CFG_LIGHT_Z   = 3'd2,
    CFG_DIFFUSE   = 3'd3,
    CFG_SPECULAR  = 3'd4,
    CFG_AMBIENT   = 3'd5,
    CFG_SHININESS = 3'd6
  } cfg_idx_e;

endpackage

FILE: src/blinn_phong_directional_shader.sv
`timescale 1ns / 1ps
// One pixel per cycle while the output is not stalled by m_axis_tready.
// Depth is set by the 17-stage square root, the FRAC_BITS + 2 stage divider
// and the 255-stage specular power chain, all stalled together by the output.
// Reset clears all valid bits and loads the register reset values; config
// writes are always accepted, as cfg_ready_o is tied high.
// ----------------------------------------------------------------------------
// blinn_phong_directional_shader
// Directional Blinn-Phong pixel shader, fully pipelined.
// ----------------------------------------------------------------------------
module blinn_phong_directional_shader import bpd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RgbW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // normal_x, normal_y, normal_z, eye_x, eye_y, eye_z
  input  logic [6*VecW-1:0]   s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // red, green, blue
  output logic [RgbW-1:0]     m_axis_tdata,
  // lit
  output logic                m_axis_tuser
);

  localparam int unsigned DtW  = 32 - FRAC_BITS;
  localparam int unsigned SW   = FRAC_BITS + 1;
  localparam int unsigned ColW2 = DtW + 17;
  localparam int unsigned S1W  = HhW + DtW + 1;
  localparam int unsigned S2W  = DtW + 1;

  logic [VecW-1:0] ldx_q, ldy_q, ldz_q;
  logic [RgbW-1:0] diff_q, spec_rgb_q, amb_q;
  logic [7:0]      shin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldx_q      <= '0;
      ldy_q      <= 16'hC000;
      ldz_q      <= '0;
      diff_q     <= '0;
      spec_rgb_q <= '0;
      amb_q      <= '0;
      shin_q     <= 8'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LIGHT_X:   ldx_q      <= cfg_data_i[VecW-1:0];
        CFG_LIGHT_Y:   ldy_q      <= cfg_data_i[VecW-1:0];
        CFG_LIGHT_Z:   ldz_q      <= cfg_data_i[VecW-1:0];
        CFG_DIFFUSE:   diff_q     <= cfg_data_i;
        CFG_SPECULAR:  spec_rgb_q <= cfg_data_i;
        CFG_AMBIENT:   amb_q      <= cfg_data_i;
        CFG_SHININESS: shin_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  vec_t  nrm [3];
  vec_t  eye [3];
  lvec_t lgt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm[k] = s_axis_tdata[k*VecW +: VecW];
      eye[k] = s_axis_tdata[(k+3)*VecW +: VecW];
    end
    lgt[0] = -lvec_t'($signed(ldx_q));
    lgt[1] = -lvec_t'($signed(ldy_q));
    lgt[2] = -lvec_t'($signed(ldz_q));
  end

  logic           f_vld, f_pos;
  logic [DtW-1:0] f_dterm;
  logic [HhW-1:0] f_hh, f_hn;

  bpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid && s_axis_tready),
    .normal_i(nrm), .eye_i(eye), .light_i(lgt),
    .valid_o(f_vld), .pos_o(f_pos), .dterm_o(f_dterm), .hh_o(f_hh), .hn_o(f_hn)
  );

  logic            q_vld;
  logic [LenW-1:0] q_len;
  logic [S1W-1:0]  q_side;

  bpd_isqrt #(.SIDE_W(S1W)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_vld), .rad_i(f_hh),
    .side_i({f_hn, f_dterm, f_pos}),
    .valid_o(q_vld), .root_o(q_len), .side_o(q_side)
  );

  logic           d_vld;
  logic [SW-1:0]  d_base;
  logic [S2W-1:0] d_side;

  bpd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(q_vld),
    .num_i(q_side[S1W-1 -: HhW]), .den_i(q_len), .side_i(q_side[S2W-1:0]),
    .valid_o(d_vld), .base_o(d_base), .side_o(d_side)
  );

  logic           p_vld;
  logic [SW-1:0]  p_spec;
  logic [S2W-1:0] p_side;

  bpd_pow #(.FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_pow (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_vld), .base_i(d_base),
    .shininess_i(shin_q), .side_i(d_side),
    .valid_o(p_vld), .spec_o(p_spec), .side_o(p_side)
  );

  // color products
  logic                  c_vld_q, c_pos_q;
  logic [DtW+ColW-1:0]   pd_q [3];
  logic [SW+ColW-1:0]    ps_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q   <= p_vld;
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pos_q <= p_side[0];
      for (int k = 0; k < 3; k++) begin
        pd_q[k] <= p_side[S2W-1:1] * diff_q[k*ColW +: ColW];
        ps_q[k] <= p_spec * spec_rgb_q[k*ColW +: ColW];
      end
    end
  end

  logic [ColW2-1:0] col   [3];
  logic [RgbW-1:0]  clamp_rgb;
  logic             over;

  always_comb begin
    over = 1'b0;
    for (int k = 0; k < 3; k++) begin
      col[k] = ColW2'(pd_q[k] >> FRAC_BITS) + ColW2'(ps_q[k] >> FRAC_BITS);
      if (col[k] > ColW2'(amb_q[k*ColW +: ColW])) begin
        over = 1'b1;
      end
      clamp_rgb[k*ColW +: ColW] = (col[k] > (ColW2'(1) << FRAC_BITS))
                                ? ColW'(ColW2'(1) << FRAC_BITS) : col[k][ColW-1:0];
    end
    over = over && c_pos_q;
  end

  logic [RgbW-1:0] out_rgb_q;
  logic            out_lit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rgb_q <= over ? clamp_rgb : amb_q;
      out_lit_q <= over;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_rgb_q;
  assign m_axis_tuser  = out_lit_q;

endmodule

FILE: src/bpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_front
// Three stages: N.L, half vector H, H.H and H.N.
// ----------------------------------------------------------------------------
module bpd_front import bpd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  localparam int unsigned DtW = 32 - FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vec_t                normal_i [3],
  input  vec_t                eye_i    [3],
  input  lvec_t               light_i  [3],
  output logic                valid_o,
  output logic                pos_o,
  output logic [DtW-1:0]      dterm_o,
  output logic [HhW-1:0]      hh_o,
  output logic [HhW-1:0]      hn_o
);

  logic [2:0] vld_q;

  logic signed [32:0] pnl_q [3];
  logic signed [17:0] h_q   [3];
  vec_t               n_q   [3];

  logic signed [34:0] dot_q;
  logic signed [35:0] hh_q  [3];
  logic signed [33:0] hnp_q [3];

  logic               pos_q;
  logic [DtW-1:0]     dterm_q;
  logic [HhW-1:0]     hh_sum_q;
  logic [HhW-1:0]     hn_sum_q;

  logic signed [34:0] dot_d;
  logic signed [37:0] hh_d;
  logic signed [35:0] hn_d;

  always_comb begin
    dot_d = 35'(pnl_q[0]) + 35'(pnl_q[1]) + 35'(pnl_q[2]);
    hh_d  = 38'(hh_q[0]) + 38'(hh_q[1]) + 38'(hh_q[2]);
    hn_d  = 36'(hnp_q[0]) + 36'(hnp_q[1]) + 36'(hnp_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pnl_q[k] <= normal_i[k] * light_i[k];
        h_q[k]   <= 18'(light_i[k]) + 18'(eye_i[k]);
        n_q[k]   <= normal_i[k];
        hh_q[k]  <= h_q[k] * h_q[k];
        hnp_q[k] <= h_q[k] * n_q[k];
      end
      dot_q    <= dot_d;
      pos_q    <= dot_q > 35'sd0;
      dterm_q  <= dot_q[FRAC_BITS +: DtW];
      hh_sum_q <= hh_d[HhW-1:0];
      hn_sum_q <= (hn_d > 36'sd0) ? hn_d[HhW-1:0] : '0;
    end
  end

  assign valid_o = vld_q[2];
  assign pos_o   = pos_q;
  assign dterm_o = dterm_q;
  assign hh_o    = hh_sum_q;
  assign hn_o    = hn_sum_q;

endmodule

FILE: src/bpd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bpd_isqrt import bpd_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [HhW-1:0]    rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [LenW-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned N  = LenW;
  localparam int unsigned RW = HhW + 1;

  logic [N-1:0]      vld_q;
  logic [RW-1:0]     v_q    [N];
  logic [RW-1:0]     r_q    [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [RW-1:0]     v_d    [N];
  logic [RW-1:0]     r_d    [N];

  always_comb begin
    logic [RW-1:0] vp;
    logic [RW-1:0] rp;
    logic [RW-1:0] bt;
    for (int i = 0; i < N; i++) begin
      vp = (i == 0) ? RW'(rad_i) : v_q[(i == 0) ? 0 : i - 1];
      rp = (i == 0) ? '0 : r_q[(i == 0) ? 0 : i - 1];
      bt = RW'(1) << (2 * (N - 1 - i));
      if (vp >= rp + bt) begin
        v_d[i] = vp - (rp + bt);
        r_d[i] = (rp >> 1) + bt;
      end else begin
        v_d[i] = vp;
        r_d[i] = rp >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        v_q[i]    <= v_d[i];
        r_q[i]    <= r_d[i];
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = r_q[N-1][LenW-1:0];
  assign side_o  = side_q[N-1];

endmodule

FILE: src/bpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_div
// Pipelined restoring divider, quotient saturated at one.
// ----------------------------------------------------------------------------
module bpd_div import bpd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [HhW-1:0]     num_i,
  input  logic [LenW-1:0]    den_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [FRAC_BITS:0] base_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int unsigned N  = FRAC_BITS + 2;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned CW = 48;

  logic [N-1:0]      vld_q;
  logic [HhW-1:0]    rem_q  [N];
  logic [LenW-1:0]   den_q  [N];
  logic [QW-1:0]     quo_q  [N];
  logic              sat_q  [N];
  logic              zero_q [N];
  logic [SIDE_W-1:0] side_q [N];

  logic [HhW-1:0]    rem_d  [N];
  logic [QW-1:0]     quo_d  [N];
  logic [QW-1:0]     quo_fin;

  always_comb begin
    logic [CW-1:0] dsh;
    for (int i = 0; i < N; i++) begin
      rem_d[i] = num_i;
      quo_d[i] = '0;
      if (i > 0) begin
        dsh = CW'(den_q[i-1]) << (FRAC_BITS + 1 - i);
        if (CW'(rem_q[i-1]) >= dsh) begin
          rem_d[i] = rem_q[i-1] - dsh[HhW-1:0];
          quo_d[i] = quo_q[i-1] | (QW'(1) << (FRAC_BITS + 1 - i));
        end else begin
          rem_d[i] = rem_q[i-1];
          quo_d[i] = quo_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      den_q[0]  <= den_i;
      sat_q[0]  <= (num_i >> (FRAC_BITS + 1)) >= HhW'(den_i);
      zero_q[0] <= den_i == '0;
      side_q[0] <= side_i;
      for (int i = 1; i < N; i++) begin
        rem_q[i]  <= rem_d[i];
        quo_q[i]  <= quo_d[i];
        den_q[i]  <= den_q[i-1];
        sat_q[i]  <= sat_q[i-1];
        zero_q[i] <= zero_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_comb begin
    quo_fin = quo_q[N-1];
    if (zero_q[N-1]) begin
      base_o = '0;
    end else if (sat_q[N-1] || quo_fin > (QW'(1) << FRAC_BITS)) begin
      base_o = QW'(1) << FRAC_BITS;
    end else begin
      base_o = quo_fin;
    end
  end

  assign valid_o = vld_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

FILE: src/bpd_pow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pow
// Specular power: one truncating multiply per stage, gated by shininess.
// ----------------------------------------------------------------------------
module bpd_pow import bpd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [FRAC_BITS:0] base_i,
  input  logic [7:0]         shininess_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [FRAC_BITS:0] spec_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int unsigned N  = ShineMax;
  localparam int unsigned SW = FRAC_BITS + 1;

  logic [N-1:0]      vld_q;
  logic [SW-1:0]     spec_q [N];
  logic [SW-1:0]     base_q [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [SW-1:0]     spec_d [N];

  always_comb begin
    logic [SW-1:0]   sp;
    logic [SW-1:0]   bs;
    logic [2*SW-1:0] prod;
    for (int i = 0; i < N; i++) begin
      sp   = (i == 0) ? (SW'(1) << FRAC_BITS) : spec_q[(i == 0) ? 0 : i - 1];
      bs   = (i == 0) ? base_i : base_q[(i == 0) ? 0 : i - 1];
      prod = sp * bs;
      spec_d[i] = (i < int'(shininess_i)) ? prod[FRAC_BITS +: SW] : sp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec_q[0] <= spec_d[0];
      base_q[0] <= base_i;
      side_q[0] <= side_i;
      for (int i = 1; i < N; i++) begin
        spec_q[i] <= spec_d[i];
        base_q[i] <= base_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign spec_o  = spec_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the directional Blinn-Phong shader. The bench
// programs light and material registers in several phases, sends directed and
// random normal/eye requests with random gaps and output stalls, and compares
// every shaded pixel with a built-in fixed-point shading model.
// ----------------------------------------------------------------------------
module tb_top;
  import bpd_pkg::*;

  localparam int unsigned FracBits = FracBitsDef;
  localparam longint     OneFx    = longint'(1) << FracBits;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic       lit;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  class shade_scoreboard;
    logic signed [15:0] light [3];
    logic [RgbW-1:0]    diffuse, specular, ambient;
    logic [7:0]         shine;
    pixel_t             pending_colors [$];
    int                 mismatches;

    function new();
      light[0] = 0; light[1] = -16'sd16384; light[2] = 0;
      diffuse = 0; specular = 0; ambient = 0; shine = 5;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [RgbW-1:0] data);
      case (idx)
        CFG_LIGHT_X:   light[0] = data[15:0];
        CFG_LIGHT_Y:   light[1] = data[15:0];
        CFG_LIGHT_Z:   light[2] = data[15:0];
        CFG_DIFFUSE:   diffuse  = data;
        CFG_SPECULAR:  specular = data;
        CFG_AMBIENT:   ambient  = data;
        CFG_SHININESS: shine    = data[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_pixel(logic [6*VecW-1:0] req);
      longint n [3], e [3], l [3], h [3];
      longint dot, hn, hh, len, base, spec, dterm, col [3];
      pixel_t p;
      bit over;
      over = 0;
      for (int k = 0; k < 3; k++) begin
        n[k] = longint'($signed(req[16*k +: 16]));
        e[k] = longint'($signed(req[16*(k+3) +: 16]));
        l[k] = -longint'(light[k]);
      end
      dot = n[0]*l[0] + n[1]*l[1] + n[2]*l[2];
      if (dot > 0) begin
        dterm = dot >>> FracBits;
        for (int k = 0; k < 3; k++) h[k] = l[k] + e[k];
        hh  = h[0]*h[0] + h[1]*h[1] + h[2]*h[2];
        len = floor_sqrt(hh);
        hn  = h[0]*n[0] + h[1]*n[1] + h[2]*n[2];
        base = (hn > 0 && len > 0) ? hn / len : 0;
        if (base > OneFx) base = OneFx;
        spec = OneFx;
        for (int i = 0; i < shine; i++) spec = (spec * base) >>> FracBits;
        for (int k = 0; k < 3; k++) begin
          col[k] = ((dterm * longint'(diffuse[16*k +: 16])) >>> FracBits)
                 + ((spec * longint'(specular[16*k +: 16])) >>> FracBits);
          if (col[k] > longint'(ambient[16*k +: 16])) over = 1;
        end
      end
      if (over) begin
        p.red   = 16'((col[0] > OneFx) ? OneFx : col[0]);
        p.green = 16'((col[1] > OneFx) ? OneFx : col[1]);
        p.blue  = 16'((col[2] > OneFx) ? OneFx : col[2]);
        p.lit   = 1'b1;
      end else begin
        p = {1'b0, ambient};
      end
      pending_colors.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", got);
        return;
      end
      want = pending_colors.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp r=%h g=%h b=%h lit=%b got r=%h g=%h b=%h lit=%b",
                   want.red, want.green, want.blue, want.lit,
                   got.red, got.green, got.blue, got.lit);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [RgbW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [6*VecW-1:0]   s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RgbW-1:0]     m_axis_tdata;
  logic                m_axis_tuser;

  shade_scoreboard sb = new();
  int  out_stall = 0;
  bit  no_idle = 0;

  always #5 clk_i = ~clk_i;

  blinn_phong_directional_shader DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_pixel({m_axis_tuser, m_axis_tdata});
      out_stall = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (out_stall == 0);
    if (out_stall > 0) out_stall--;
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RgbW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic signed [15:0] n [3], logic signed [15:0] e [3]);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {e[2], e[1], e[0], n[2], n[1], n[0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel({e[2], e[1], e[0], n[2], n[1], n[0]});
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (sb.pending_colors.size() == 0);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [RgbW-1:0] rand_rgb();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // random light direction, each component within [-1.0, 1.0]; phases 1 and 2 fix it
  task automatic program_phase(int ph);
    logic [RgbW-1:0] dif, spc, amb;
    logic [7:0] sh;
    logic signed [15:0] lx, ly, lz;
    lx = rand_comp(); ly = rand_comp(); lz = rand_comp();
    dif = rand_rgb(); spc = rand_rgb(); amb = {3{16'($urandom_range(0, 4000))}};
    case (ph)
      1: begin lx = 16'sd16384; ly = 0; lz = 0; sh = 8'd1; amb = '0;
               dif = {3{16'hFFFF}}; spc = {3{16'hFFFF}}; end
      2: begin lx = 0; ly = 0; lz = -16'sd16384; sh = 8'd128; dif = '0; end
      3: begin sh = 8'd0; amb = {3{16'hFFFF}}; end
      4: begin sh = 8'd255; spc = {3{16'h4000}}; end
      default: sh = 8'($urandom_range(1, 128));
    endcase
    write_reg(CFG_LIGHT_X, RgbW'(lx));
    write_reg(CFG_LIGHT_Y, RgbW'(ly));
    write_reg(CFG_LIGHT_Z, RgbW'(lz));
    write_reg(CFG_DIFFUSE, dif);
    write_reg(CFG_SPECULAR, spc);
    write_reg(CFG_AMBIENT, amb);
    write_reg(CFG_SHININESS, RgbW'(sh));
    write_reg(CfgUnused, rand_rgb());
  endtask

  task automatic random_pixels(int count);
    logic signed [15:0] n [3], e [3];
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) begin
        n[k] = rand_comp();
        e[k] = rand_comp();
      end
      // bias normal toward the light so most pixels take the lit path
      if ($urandom_range(0, 3) != 0)
        for (int k = 0; k < 3; k++)
          if (sb.light[k] != 0 && ((n[k] < 0) == (sb.light[k] < 0))) n[k] = -n[k];
      // eye opposite to the light: zero half vector
      if ($urandom_range(0, 15) == 0)
        for (int k = 0; k < 3; k++) e[k] = sb.light[k];
      send_pixel(n, e);
    end
    no_idle = 0;
  endtask

  initial begin
    logic signed [15:0] n [3], e [3];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: light along -y, so L = +y
    write_reg(CFG_DIFFUSE, {16'h2000, 16'h3000, 16'h4000});
    write_reg(CFG_SPECULAR, {16'hFFFF, 16'h8000, 16'h0001});
    write_reg(CFG_AMBIENT, {16'h0100, 16'h0000, 16'h0200});
    n = '{0, 16384, 0};       e = '{0, 16384, 0};       send_pixel(n, e);
    n = '{0, -16384, 0};      e = '{0, 16384, 0};       send_pixel(n, e);
    n = '{16384, 0, 0};       e = '{0, 0, 16384};       send_pixel(n, e);
    n = '{0, 16384, 0};       e = '{0, -16384, 0};      send_pixel(n, e);
    n = '{16384, 16384, 16384}; e = '{16384, 16384, 16384}; send_pixel(n, e);
    n = '{-16384, 16384, -16384}; e = '{-16384, -16384, 16384}; send_pixel(n, e);
    n = '{0, 1, 0};           e = '{0, 0, 0};           send_pixel(n, e);
    n = '{11585, 11585, 0};   e = '{0, 11585, 11585};   send_pixel(n, e);
    n = '{-32768, 16384, 32767}; e = '{32767, -32768, -1}; send_pixel(n, e);
    random_pixels(15);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      program_phase(ph);
      random_pixels(50);
      if (ph == 2) drain();
      random_pixels(45);
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_colors.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
src/bpd_pkg.sv
src/bpd_front.sv
src/bpd_isqrt.sv
src/bpd_div.sv
src/bpd_pow.sv
src/blinn_phong_directional_shader.sv
tb/sv/tb_top.sv
